// File: rtl/rc4_pkg.sv
// Shared package for the RC4 keystream generator: sizes, opcodes, sequencer step codes,
// the control-word layout with its microcode table, and the permutation request bundle.
// Used by rc4_perm and rc4_keystream_generator; depends on nothing.
package rc4_pkg;

    localparam int PERM_DEPTH       = 256;
    localparam int PERM_AW          = 8;
    localparam int MAX_KEY_BYTES_DEF = 64;
    localparam int RUN_LIMIT        = 64;
    localparam logic [6:0] KEY_LENGTH_RESET = 7'd40;

    // Request opcodes.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_INIT = 2'd1;
    localparam logic [1:0] OP_GEN  = 2'd2;

    // Sequencer step addresses.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] K_INIT = 4'd1;
    localparam logic [3:0] K_RDK  = 4'd2;
    localparam logic [3:0] K_SWJ  = 4'd3;
    localparam logic [3:0] K_WRK  = 4'd4;
    localparam logic [3:0] K_WRJ  = 4'd5;
    localparam logic [3:0] K_END  = 4'd6;
    localparam logic [3:0] G_RDI  = 4'd7;
    localparam logic [3:0] G_SWJ  = 4'd8;
    localparam logic [3:0] G_WRI  = 4'd9;
    localparam logic [3:0] G_WRJ  = 4'd10;
    localparam logic [3:0] G_RDT  = 4'd11;
    localparam logic [3:0] G_OUT  = 4'd12;

    // Permutation read address select.
    localparam logic [2:0] RD_NONE  = 3'd0;
    localparam logic [2:0] RD_I_INC = 3'd1;
    localparam logic [2:0] RD_J_SUM = 3'd2;
    localparam logic [2:0] RD_K     = 3'd3;
    localparam logic [2:0] RD_T     = 3'd4;

    // Permutation write select.
    localparam logic [1:0] WR_NONE = 2'd0;
    localparam logic [1:0] WR_I    = 2'd1;
    localparam logic [1:0] WR_K    = 2'd2;
    localparam logic [1:0] WR_J    = 2'd3;

    // Second index update.
    localparam logic [1:0] J_HOLD    = 2'd0;
    localparam logic [1:0] J_CLEAR   = 2'd1;
    localparam logic [1:0] J_ADD     = 2'd2;
    localparam logic [1:0] J_ADD_KEY = 2'd3;

    // First index update.
    localparam logic [1:0] I_HOLD  = 2'd0;
    localparam logic [1:0] I_CLEAR = 2'd1;
    localparam logic [1:0] I_INC   = 2'd2;

    // Sequencing.
    localparam logic [1:0] SEQ_NEXT   = 2'd0;
    localparam logic [1:0] SEQ_DONE   = 2'd1;
    localparam logic [1:0] SEQ_LOOP_K = 2'd2;
    localparam logic [1:0] SEQ_LOOP_G = 2'd3;

    typedef struct packed {
        logic [2:0] rd;
        logic [1:0] wr;
        logic [1:0] jop;
        logic [1:0] iop;
        logic       k_clr;
        logic       k_step;
        logic       key_rd;
        logic       ld_si;
        logic       ld_sj;
        logic       clr_valid;
        logic       emit;
        logic [1:0] seq;
        logic [3:0] target;
    } ucode_t;

    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
    } perm_req_t;

    // Microcode table: one control word per step.
    function automatic ucode_t ucode_rom(input logic [3:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            S_IDLE:
            begin
                w.seq = SEQ_DONE;
            end
            K_INIT:
            begin
                w.clr_valid = 1'b1;
                w.k_clr     = 1'b1;
                w.jop       = J_CLEAR;
                w.seq       = SEQ_NEXT;
            end
            K_RDK:
            begin
                w.rd     = RD_K;
                w.key_rd = 1'b1;
                w.seq    = SEQ_NEXT;
            end
            K_SWJ:
            begin
                w.ld_si = 1'b1;
                w.jop   = J_ADD_KEY;
                w.rd    = RD_J_SUM;
                w.seq   = SEQ_NEXT;
            end
            K_WRK:
            begin
                w.wr  = WR_K;
                w.seq = SEQ_NEXT;
            end
            K_WRJ:
            begin
                w.wr     = WR_J;
                w.k_step = 1'b1;
                w.seq    = SEQ_LOOP_K;
                w.target = K_RDK;
            end
            K_END:
            begin
                w.iop = I_CLEAR;
                w.jop = J_CLEAR;
                w.seq = SEQ_DONE;
            end
            G_RDI:
            begin
                w.iop = I_INC;
                w.rd  = RD_I_INC;
                w.seq = SEQ_NEXT;
            end
            G_SWJ:
            begin
                w.ld_si = 1'b1;
                w.jop   = J_ADD;
                w.rd    = RD_J_SUM;
                w.seq   = SEQ_NEXT;
            end
            G_WRI:
            begin
                w.wr    = WR_I;
                w.ld_sj = 1'b1;
                w.seq   = SEQ_NEXT;
            end
            G_WRJ:
            begin
                w.wr  = WR_J;
                w.seq = SEQ_NEXT;
            end
            G_RDT:
            begin
                w.rd  = RD_T;
                w.seq = SEQ_NEXT;
            end
            G_OUT:
            begin
                w.emit   = 1'b1;
                w.seq    = SEQ_LOOP_G;
                w.target = G_RDI;
            end
            default:
            begin
                w.seq = SEQ_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/rc4_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Reads return the data held before a write at the same edge. No dependencies.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rc4_perm.sv
// Permutation store: a 256-entry RAM plus one valid bit per entry, so that an entry
// never written since reset or since the last clear reads as its own index.
// Depends on rc4_pkg and rc4_ram.
module rc4_perm (
    input  logic                clk,
    input  logic                rst_n,
    input  rc4_pkg::perm_req_t  req,
    output logic [7:0]          rd_data
);

    logic [rc4_pkg::PERM_DEPTH-1:0] valid_reg;
    logic                           rd_valid_reg;
    logic [rc4_pkg::PERM_AW-1:0]    rd_addr_reg;
    logic [7:0]                     ram_q;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_addr_reg <= req.rd_addr;
        end
    end

    // An entry that is not valid holds the identity value.
    assign rd_data = rd_valid_reg ? ram_q : rd_addr_reg;

endmodule

// File: rtl/rc4_keystream_generator.sv
// RC4 keystream generator. A load-key request never raises busy. A key-schedule request
// keeps busy high through a clear step, 256 swaps of four steps each and an end step.
// A generate request of n bytes keeps busy high through six steps per byte and strobes
// each byte after the output step of its pass; a new request waits until the run is done.
// Results cannot be stalled. Reset gives the identity permutation,
// zero indices and a key length of 40; the key store is undefined until written.
module rc4_keystream_generator #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // Request channel.
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [5:0] key_index,
    input  logic [7:0] key_byte,
    input  logic [6:0] byte_count,
    // Configuration channel: key length.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data,
    // Result channel.
    output logic       result_strobe,
    output logic [7:0] keystream_byte,
    output logic       last
);

    // Key store address width, and the width that holds a key length up to the store size.
    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KLW = $clog2(MAX_KEY_BYTES + 1);

    // Sequencer state.
    logic [3:0]     pc_reg, pc_next;
    rc4_pkg::ucode_t uc;

    // Datapath registers.
    logic [7:0]     i_reg, i_next;
    logic [7:0]     j_reg, j_next;
    logic [7:0]     k_reg;
    logic [KLW-1:0] kp_reg;
    logic [7:0]     si_reg;
    logic [7:0]     sj_reg;
    logic [6:0]     cnt_reg, cnt_next;
    logic [6:0]     key_length_reg;
    logic           strobe_reg;
    logic [7:0]     ks_reg;
    logic           last_reg;

    logic                accept;
    logic [6:0]          count_sat;
    logic [KLW-1:0]      len_eff;
    logic [KLW-1:0]      kp_step;
    logic [7:0]          perm_rd;
    logic [7:0]          key_rd;
    logic [7:0]          key_term;
    logic [7:0]          j_sum;
    logic                key_wr_en;
    rc4_pkg::perm_req_t  perm_req;

    // The control word for the current step comes straight from the microcode table.
    assign uc     = rc4_pkg::ucode_rom(pc_reg);
    assign busy   = (pc_reg != rc4_pkg::S_IDLE);
    assign accept = start && !busy;

    // The user must keep configuration writes to idle; unchecked, the port is always open.
    assign cfg_ready = 1'b1;

    // A run longer than the limit is clipped to the limit.
    assign count_sat = (byte_count > 7'(rc4_pkg::RUN_LIMIT)) ? 7'(rc4_pkg::RUN_LIMIT)
                                                             : byte_count;

    // Effective key length: zero counts as one and anything past the store is clipped.
    always_comb
    begin
        if (key_length_reg == 7'd0)
        begin
            len_eff = KLW'(1);
        end
        else if (int'(key_length_reg) > MAX_KEY_BYTES)
        begin
            len_eff = KLW'(MAX_KEY_BYTES);
        end
        else
        begin
            len_eff = KLW'(key_length_reg);
        end
    end

    // The key position wraps back to zero after the last key byte in use.
    assign kp_step = (int'(kp_reg) + 1 == int'(len_eff)) ? '0 : KLW'(int'(kp_reg) + 1);

    // Key bytes are written straight from the request; a position past the store is dropped.
    assign key_wr_en = accept && (opcode == rc4_pkg::OP_LOAD)
                       && (int'(key_index) < MAX_KEY_BYTES);

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (KAW'(key_index)),
        .wr_data (key_byte),
        .rd_en   (uc.key_rd),
        .rd_addr (KAW'(kp_reg)),
        .rd_data (key_rd)
    );

    // The new second index is formed from the permutation value just read, plus the key
    // byte during the key schedule. It also addresses the next permutation read.
    assign key_term = (uc.jop == rc4_pkg::J_ADD_KEY) ? key_rd : 8'd0;
    assign j_sum    = j_reg + perm_rd + key_term;

    always_comb
    begin
        case (uc.jop)
            rc4_pkg::J_CLEAR:   j_next = 8'd0;
            rc4_pkg::J_ADD:     j_next = j_sum;
            rc4_pkg::J_ADD_KEY: j_next = j_sum;
            default:            j_next = j_reg;
        endcase
    end

    always_comb
    begin
        case (uc.iop)
            rc4_pkg::I_CLEAR: i_next = 8'd0;
            rc4_pkg::I_INC:   i_next = i_reg + 8'd1;
            default:          i_next = i_reg;
        endcase
    end

    // Permutation port requests. All swap writes take their data from the RAM output
    // or from the held first value, so a read and a write never touch the same step.
    always_comb
    begin
        perm_req       = '0;
        perm_req.clear = uc.clr_valid;
        perm_req.rd_en = (uc.rd != rc4_pkg::RD_NONE);
        case (uc.rd)
            rc4_pkg::RD_I_INC: perm_req.rd_addr = i_reg + 8'd1;
            rc4_pkg::RD_J_SUM: perm_req.rd_addr = j_sum;
            rc4_pkg::RD_K:     perm_req.rd_addr = k_reg;
            rc4_pkg::RD_T:     perm_req.rd_addr = si_reg + sj_reg;
            default:           perm_req.rd_addr = 8'd0;
        endcase
        perm_req.wr_en = (uc.wr != rc4_pkg::WR_NONE);
        case (uc.wr)
            rc4_pkg::WR_I:
            begin
                perm_req.wr_addr = i_reg;
                perm_req.wr_data = perm_rd;
            end
            rc4_pkg::WR_K:
            begin
                perm_req.wr_addr = k_reg;
                perm_req.wr_data = perm_rd;
            end
            rc4_pkg::WR_J:
            begin
                perm_req.wr_addr = j_reg;
                perm_req.wr_data = si_reg;
            end
            default:
            begin
                perm_req.wr_addr = 8'd0;
                perm_req.wr_data = 8'd0;
            end
        endcase
    end

    rc4_perm u_perm (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (perm_req),
        .rd_data (perm_rd)
    );

    // Next step: dispatch on the opcode when idle, otherwise follow the control word.
    always_comb
    begin
        pc_next  = pc_reg;
        cnt_next = cnt_reg;
        if (pc_reg == rc4_pkg::S_IDLE)
        begin
            if (accept)
            begin
                case (opcode)
                    rc4_pkg::OP_INIT:
                    begin
                        pc_next = rc4_pkg::K_INIT;
                    end
                    rc4_pkg::OP_GEN:
                    begin
                        if (byte_count != 7'd0)
                        begin
                            pc_next  = rc4_pkg::G_RDI;
                            cnt_next = count_sat;
                        end
                    end
                    default:
                    begin
                        pc_next = rc4_pkg::S_IDLE;
                    end
                endcase
            end
        end
        else
        begin
            if (uc.emit)
            begin
                cnt_next = cnt_reg - 7'd1;
            end
            case (uc.seq)
                rc4_pkg::SEQ_NEXT:
                begin
                    pc_next = pc_reg + 4'd1;
                end
                rc4_pkg::SEQ_LOOP_K:
                begin
                    pc_next = (k_reg == 8'hFF) ? pc_reg + 4'd1 : uc.target;
                end
                rc4_pkg::SEQ_LOOP_G:
                begin
                    pc_next = (cnt_reg == 7'd1) ? rc4_pkg::S_IDLE : uc.target;
                end
                default:
                begin
                    pc_next = rc4_pkg::S_IDLE;
                end
            endcase
        end
    end

    // Control state and the architectural indices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= rc4_pkg::S_IDLE;
            cnt_reg        <= 7'd0;
            i_reg          <= 8'd0;
            j_reg          <= 8'd0;
            key_length_reg <= rc4_pkg::KEY_LENGTH_RESET;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            strobe_reg <= uc.emit;
            if (cfg_valid && cfg_ready)
            begin
                key_length_reg <= cfg_data;
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        if (uc.k_clr)
        begin
            k_reg  <= 8'd0;
            kp_reg <= '0;
        end
        else if (uc.k_step)
        begin
            k_reg  <= k_reg + 8'd1;
            kp_reg <= kp_step;
        end
        if (uc.ld_si)
        begin
            si_reg <= perm_rd;
        end
        if (uc.ld_sj)
        begin
            sj_reg <= perm_rd;
        end
        if (uc.emit)
        begin
            ks_reg   <= perm_rd;
            last_reg <= (cnt_reg == 7'd1);
        end
    end

    assign result_strobe  = strobe_reg;
    assign keystream_byte = ks_reg;
    assign last           = last_reg;

    // A result only follows the output step of the generate program.
    a_strobe_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> ($past(pc_reg) == rc4_pkg::G_OUT))
        else $error("result strobe without an output step");

    // The final byte of a run is shown once the sequencer is back in idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> (pc_reg == rc4_pkg::S_IDLE))
        else $error("last byte strobed while the sequencer is still running");

    // The remaining byte count never runs out inside the generate program.
    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rc4_pkg::G_RDI || pc_reg == rc4_pkg::G_SWJ || pc_reg == rc4_pkg::G_WRI
         || pc_reg == rc4_pkg::G_WRJ || pc_reg == rc4_pkg::G_RDT
         || pc_reg == rc4_pkg::G_OUT) |-> (cnt_reg != 7'd0))
        else $error("generate step with no bytes left");

    // The key position stays inside the active key during the schedule.
    a_kp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rc4_pkg::K_RDK || pc_reg == rc4_pkg::K_SWJ || pc_reg == rc4_pkg::K_WRK
         || pc_reg == rc4_pkg::K_WRJ) |-> (kp_reg < len_eff))
        else $error("key position past the key length");

    // Each run of the schedule ends with both indices cleared.
    a_sched_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == rc4_pkg::K_END) |=> (i_reg == 8'd0 && j_reg == 8'd0))
        else $error("indices not cleared after key schedule");

endmodule

// File: verif/tb_rc4_keystream_generator.sv
`timescale 1ns / 100ps
// Self-checking testbench for rc4_keystream_generator: key loads, key schedules, keystream runs.
// A scoreboard class predicts each keystream byte and its last flag from its own state copy.
// Depends on rc4_pkg for opcodes and sizes, and on the RTL of the block under test.
module tb_rc4_keystream_generator;

    // The fourth opcode value has no function. The block must ignore it.
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int KEY_SLOTS = rc4_pkg::MAX_KEY_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    // This margin covers a key schedule, which keeps the block busy, before a
    // register write or the end of the run, since a schedule gives no result to wait on.
    localparam int QUIET_CYCLES = 1100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] ks_byte;
        logic       is_last;
    } ks_result_t;

    // The scoreboard keeps a private copy of the permutation, both indices, the key store and
    // the key length. Each accepted request advances that copy, and each keystream byte it
    // predicts is queued until the block strobes the matching result.
    class rc4_keystream_scoreboard_t;
        logic [7:0] sbox [rc4_pkg::PERM_DEPTH];
        logic [7:0] i_idx;
        logic [7:0] j_idx;
        logic [7:0] key_mem [KEY_SLOTS];
        logic [6:0] key_len;
        ks_result_t expected_bytes [$];
        int         failures;
        int         checked;

        function new();
            int k;
            for (k = 0; k < rc4_pkg::PERM_DEPTH; k++)
                sbox[k] = 8'(k);
            for (k = 0; k < KEY_SLOTS; k++)
                key_mem[k] = '0;
            i_idx    = '0;
            j_idx    = '0;
            key_len  = rc4_pkg::KEY_LENGTH_RESET;
            failures = 0;
            checked  = 0;
        endfunction

        function void set_key_length(logic [6:0] len);
            key_len = len;
        endfunction

        function void swap_sbox(int a, int b);
            logic [7:0] tmp;
            tmp     = sbox[a];
            sbox[a] = sbox[b];
            sbox[b] = tmp;
        endfunction

        function void run_schedule();
            int         len;
            int         k;
            logic [7:0] j;
            // A length of zero acts as one, and the store size caps it.
            len = int'(key_len);
            if (len == 0)
                len = 1;
            if (len > KEY_SLOTS)
                len = KEY_SLOTS;
            for (k = 0; k < rc4_pkg::PERM_DEPTH; k++)
                sbox[k] = 8'(k);
            j = '0;
            for (k = 0; k < rc4_pkg::PERM_DEPTH; k++)
            begin
                j = j + sbox[k] + key_mem[k % len];
                swap_sbox(k, int'(j));
            end
            i_idx = '0;
            j_idx = '0;
        endfunction

        // Called once for every request that the block accepts.
        function void note_request(logic [1:0] op, logic [5:0] kidx, logic [7:0] kbyte,
                                   logic [6:0] cnt);
            int         n;
            int         k;
            logic [7:0] t;
            ks_result_t r;
            case (op)
                rc4_pkg::OP_LOAD:
                begin
                    if (int'(kidx) < KEY_SLOTS)
                        key_mem[kidx] = kbyte;
                end
                rc4_pkg::OP_INIT:
                begin
                    run_schedule();
                end
                rc4_pkg::OP_GEN:
                begin
                    // Counts above the run limit saturate, and a count of zero does nothing.
                    n = (int'(cnt) > rc4_pkg::RUN_LIMIT) ? rc4_pkg::RUN_LIMIT : int'(cnt);
                    for (k = 0; k < n; k++)
                    begin
                        i_idx = i_idx + 8'd1;
                        j_idx = j_idx + sbox[i_idx];
                        swap_sbox(int'(i_idx), int'(j_idx));
                        t = sbox[i_idx] + sbox[j_idx];
                        r.ks_byte = sbox[t];
                        r.is_last = (k == n - 1);
                        expected_bytes.push_back(r);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Called for every result that the block strobes.
        function void check_byte(logic [7:0] ks, logic lst);
            ks_result_t r;
            if (expected_bytes.size() == 0)
            begin
                if (failures < MAX_REPORTS)
                    $display("[%0t] unexpected keystream byte %02h last %b", $time, ks, lst);
                failures++;
            end
            else
            begin
                r = expected_bytes.pop_front();
                checked++;
                if (ks !== r.ks_byte || lst !== r.is_last)
                begin
                    if (failures < MAX_REPORTS)
                        $display({"[%0t] keystream mismatch: expected byte %02h last %b,",
                                  " got byte %02h last %b"},
                                 $time, r.ks_byte, r.is_last, ks, lst);
                    failures++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] opcode;
    logic [5:0] key_index;
    logic [7:0] key_byte;
    logic [6:0] byte_count;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;
    logic       result_strobe;
    logic [7:0] keystream_byte;
    logic       last;

    rc4_keystream_scoreboard_t keystream_board;

    // When clear, the request side issues back to back with no idle cycles.
    logic gaps_on;
    int   cycle_count = 0;
    int   n_loads;
    int   n_inits;
    int   n_gens;
    int   n_ignored;
    int   n_cfg_writes;

    rc4_keystream_generator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .key_index      (key_index),
        .key_byte       (key_byte),
        .byte_count     (byte_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .keystream_byte (keystream_byte),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            keystream_board.check_byte(keystream_byte, last);
    end

    // Drives one request, starting from a falling edge and returning on a falling edge. An
    // optional idle gap comes first. The request is accepted at the first rising edge at
    // which busy is low, and only then does the scoreboard see it.
    task automatic send_request(input logic [1:0] op, input logic [5:0] kidx,
                                input logic [7:0] kbyte, input logic [6:0] cnt);
        int gap;
        if (gaps_on && $urandom_range(0, 99) < 10)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        key_index  <= kidx;
        key_byte   <= kbyte;
        byte_count <= cnt;
        do
            @(posedge clk);
        while (busy);
        keystream_board.note_request(op, kidx, kbyte, cnt);
        case (op)
            rc4_pkg::OP_LOAD: n_loads++;
            rc4_pkg::OP_INIT: n_inits++;
            rc4_pkg::OP_GEN:  if (cnt == 7'd0) n_ignored++; else n_gens++;
            default:          n_ignored++;
        endcase
        @(negedge clk);
    endtask

    task automatic end_requests();
        start <= 1'b0;
    endtask

    // Waits until every predicted byte has come back, then lets a possible key schedule
    // finish, since a schedule gives no result that could be waited for.
    task automatic wait_block_quiet();
        while (keystream_board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the key length register. The caller has made sure that the block is idle.
    task automatic write_key_length(input logic [6:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        keystream_board.set_key_length(len);
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short keystream runs and key loads, with occasional key schedules, some zero,
    // full and oversized counts, and a few requests with the unused opcode. Fields that an
    // opcode does not use still carry random values.
    task automatic random_request();
        int         pick;
        int         cpick;
        logic [1:0] op;
        logic [6:0] cnt;
        pick = $urandom_range(0, 99);
        cnt  = 7'($urandom);
        if (pick < 30)
            op = rc4_pkg::OP_LOAD;
        else if (pick < 36)
            op = rc4_pkg::OP_INIT;
        else if (pick < 40)
            op = OP_RESERVED;
        else
        begin
            op    = rc4_pkg::OP_GEN;
            cpick = $urandom_range(0, 99);
            if (cpick < 6)
                cnt = 7'd0;
            else if (cpick < 14)
                cnt = 7'($urandom_range(65, 127));
            else if (cpick < 22)
                cnt = 7'd64;
            else
                cnt = 7'($urandom_range(1, 16));
        end
        send_request(op, 6'($urandom), 8'($urandom), cnt);
    endtask

    initial
    begin
        logic [6:0] phase_len [5];
        int         p;
        int         k;
        int         leftover;

        // Every input is known from time zero, while reset is held.
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = rc4_pkg::OP_LOAD;
        key_index    = '0;
        key_byte     = '0;
        byte_count   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        gaps_on      = 1'b1;
        n_loads      = 0;
        n_inits      = 0;
        n_gens       = 0;
        n_ignored    = 0;
        n_cfg_writes = 0;
        keystream_board = new();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Keystream straight from the reset permutation, a zero count, the
        // unused opcode, an oversized count and a full run. Then key bytes at both ends of
        // the store with extreme values.
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd1);
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd0);
        send_request(OP_RESERVED, 6'($urandom), 8'($urandom), 7'($urandom));
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd127);
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd64);
        send_request(rc4_pkg::OP_LOAD, 6'd63, 8'h00, 7'($urandom));
        send_request(rc4_pkg::OP_LOAD, 6'd0, 8'hFF, 7'($urandom));

        // A key length of zero must behave like a length of one. Only key byte 0 is read.
        end_requests();
        wait_block_quiet();
        write_key_length(7'd0);
        send_request(rc4_pkg::OP_INIT, 6'($urandom), 8'($urandom), 7'($urandom));
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd5);

        // The shortest legal key, run with a different value in key byte 0.
        end_requests();
        wait_block_quiet();
        write_key_length(7'd1);
        send_request(rc4_pkg::OP_INIT, 6'($urandom), 8'($urandom), 7'($urandom));
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd3);
        send_request(rc4_pkg::OP_LOAD, 6'd0, 8'h00, 7'($urandom));
        send_request(rc4_pkg::OP_INIT, 6'($urandom), 8'($urandom), 7'($urandom));
        send_request(rc4_pkg::OP_GEN, 6'($urandom), 8'($urandom), 7'd2);

        // Fill the whole key store with random bytes, so that no later key schedule can read
        // an entry that was never written.
        for (k = 0; k < KEY_SLOTS; k++)
            send_request(rc4_pkg::OP_LOAD, k[5:0], 8'($urandom), 7'($urandom));

        // Random phases, each under its own key length: the full store, a length above the
        // store size, the reset value, and a random length on each side of the store size.
        // The third phase runs with no idle cycles on the request side.
        phase_len[0] = 7'd64;
        phase_len[1] = 7'd127;
        phase_len[2] = rc4_pkg::KEY_LENGTH_RESET;
        phase_len[3] = 7'($urandom_range(2, 63));
        phase_len[4] = 7'($urandom_range(65, 126));
        for (p = 0; p < 5; p++)
        begin
            end_requests();
            wait_block_quiet();
            write_key_length(phase_len[p]);
            gaps_on = (p != 2);
            send_request(rc4_pkg::OP_INIT, 6'($urandom), 8'($urandom), 7'($urandom));
            repeat (78) random_request();
        end
        end_requests();

        // Drain, then leave room for a trailing key schedule or a stray result.
        while (keystream_board.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        leftover = keystream_board.expected_bytes.size();
        if (leftover != 0)
        begin
            $display("%0d predicted keystream bytes never arrived", leftover);
            keystream_board.failures += leftover;
        end

        $display("Covered %0d key loads, %0d key schedules, %0d keystream runs,",
                 n_loads, n_inits, n_gens);
        $display("%0d ignored requests and %0d key length writes; %0d bytes checked, %0d failures.",
                 n_ignored, n_cfg_writes, keystream_board.checked, keystream_board.failures);
        if (keystream_board.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_perm.sv
rtl/rc4_keystream_generator.sv
verif/tb_rc4_keystream_generator.sv
